/* hw/rtl/pwft_pkg.sv */
// pwft_pkg: types, widths and reset values shared by the pulse-width frame sender
// no dependencies

package pwft_pkg;

  localparam int TIME_W          = 16;
  localparam int PERIOD_W        = 16;
  localparam int DATA_W          = 26;
  localparam int FRAME_BITS_DEF  = 26;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 26;

  localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 16'd1000;
  localparam logic [DATA_W-1:0]   DATA_WORD_RST   = 26'd61455;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WORD   = 1'd1;

  localparam logic ACT_COMPARE = 1'b0;
  localparam logic ACT_START   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_GAP        = 3'd1,
    PH_START_LOW  = 3'd2,
    PH_START_HIGH = 3'd3,
    PH_DATA_LOW   = 3'd4,
    PH_DATA_HIGH  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    UNITS_1,
    UNITS_2,
    UNITS_5
  } units_t;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] capture_time;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] next_compare;
    logic              pin_level;
    logic              stop_timer;
  } res_t;

endpackage

/* hw/rtl/pwft_channels.sv */
// pwft channel interfaces: input request, result and register write channels
// depends on pwft_pkg

interface pwft_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [pwft_pkg::TIME_W-1:0]    capture_time;

  modport source (output valid, output action, output capture_time, input ready);
  modport sink   (input valid, input action, input capture_time, output ready);
endinterface

interface pwft_out_if;
  logic                           valid;
  logic                           ready;
  logic [pwft_pkg::TIME_W-1:0]    next_compare;
  logic                           pin_level;
  logic                           stop_timer;

  modport source (output valid, output next_compare, output pin_level,
                  output stop_timer, input ready);
  modport sink   (input valid, input next_compare, input pin_level,
                  input stop_timer, output ready);
endinterface

interface pwft_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pwft_pkg::CFG_IDX_W-1:0]   index;
  logic [pwft_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/pwft_seq.sv */
// pwft_seq: frame phase state machine and next compare time computation
// depends on pwft_pkg

module pwft_seq #(
  parameter int FRAME_BITS = pwft_pkg::FRAME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  pwft_pkg::item_t                   item,
  input  logic [pwft_pkg::PERIOD_W-1:0]     base_period,
  input  logic [pwft_pkg::DATA_W-1:0]       data_word,
  output pwft_pkg::res_t                    res
);

  localparam int POS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

  pwft_pkg::phase_t  phase_r, phase_nxt, evt_phase;
  logic [POS_W-1:0]  pos_r, pos_nxt, evt_pos;
  logic [FRAME_BITS-1:0] frame_data;
  logic              cur_bit;
  pwft_pkg::units_t  units;
  logic              level;
  logic              stop;
  logic [pwft_pkg::TIME_W-1:0] period_x1, period_x2, period_x5, offset;

  // bits past the data register read as zero
  for (genvar i = 0; i < FRAME_BITS; i++) begin : g_frame
    if (i < pwft_pkg::DATA_W) begin : g_data
      assign frame_data[i] = data_word[i];
    end else begin : g_zero
      assign frame_data[i] = 1'b0;
    end
  end

  assign cur_bit   = frame_data[pos_r];
  assign period_x1 = base_period;
  assign period_x2 = {base_period[pwft_pkg::PERIOD_W-2:0], 1'b0};
  assign period_x5 = {base_period[pwft_pkg::PERIOD_W-3:0], 2'b00} + base_period;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pwft_pkg::PH_IDLE;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    evt_phase = pwft_pkg::PH_IDLE;
    evt_pos   = pos_r;
    units     = pwft_pkg::UNITS_1;
    level     = 1'b0;
    stop      = 1'b0;
    case (phase_r)
      pwft_pkg::PH_GAP: begin
        units     = pwft_pkg::UNITS_5;
        evt_phase = pwft_pkg::PH_START_LOW;
      end
      pwft_pkg::PH_START_LOW: begin
        units     = pwft_pkg::UNITS_2;
        evt_phase = pwft_pkg::PH_START_HIGH;
      end
      pwft_pkg::PH_START_HIGH: begin
        units     = pwft_pkg::UNITS_1;
        level     = 1'b1;
        evt_phase = pwft_pkg::PH_DATA_LOW;
        evt_pos   = LAST_POS;
      end
      pwft_pkg::PH_DATA_LOW: begin
        units     = cur_bit ? pwft_pkg::UNITS_2 : pwft_pkg::UNITS_1;
        evt_phase = pwft_pkg::PH_DATA_HIGH;
      end
      pwft_pkg::PH_DATA_HIGH: begin
        units = cur_bit ? pwft_pkg::UNITS_1 : pwft_pkg::UNITS_2;
        level = 1'b1;
        if (pos_r == '0) begin
          evt_phase = pwft_pkg::PH_IDLE;
        end else begin
          evt_phase = pwft_pkg::PH_DATA_LOW;
          evt_pos   = pos_r - POS_W'(1);
        end
      end
      default: begin
        stop      = 1'b1;
        evt_phase = pwft_pkg::PH_IDLE;
      end
    endcase

    case (units)
      pwft_pkg::UNITS_2: offset = period_x2;
      pwft_pkg::UNITS_5: offset = period_x5;
      default:           offset = period_x1;
    endcase

    res.next_compare = stop ? '0 : item.capture_time + offset;
    res.pin_level    = level;
    res.stop_timer   = stop;

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    if (step) begin
      if (item.action == pwft_pkg::ACT_START) begin
        phase_nxt = pwft_pkg::PH_GAP;
        pos_nxt   = '0;
      end else begin
        phase_nxt = evt_phase;
        pos_nxt   = evt_pos;
      end
    end
  end

endmodule

/* hw/rtl/pulse_width_frame_transmitter.sv */
// Pulse-width frame sender for one output-compare pin. A start request arms the frame
// and returns nothing; every compare request returns one result with the next compare
// time, the pin level and the stop flag. A request passes an input register and a
// result register, in that order, before its result is valid; the block takes one request
// per cycle as long as results are taken, limited only by the result register. Registers
// (base period, data word) are written through the cfg channel, which is always ready;
// the user must write them only while no request is in flight, which the block itself
// does not enforce.
// depends on pwft_pkg, pwft_channels, pwft_seq

module pulse_width_frame_transmitter #(
  parameter int FRAME_BITS = pwft_pkg::FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pwft_in_if.sink     in_if,
  pwft_out_if.source  out_if,
  pwft_cfg_if.sink    cfg_if
);

  pwft_pkg::item_t                 in_item_r;
  logic                            in_vld_r, in_vld_nxt;
  pwft_pkg::res_t                  res_r, res;
  logic                            out_vld_r, out_vld_nxt;
  logic [pwft_pkg::PERIOD_W-1:0]   base_period_r;
  logic [pwft_pkg::DATA_W-1:0]     data_word_r;
  logic                            advance;
  logic                            in_acc;

  assign advance = in_vld_r && (in_item_r.action == pwft_pkg::ACT_START ||
                                !out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    in_vld_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    out_vld_nxt = out_vld_r;
    if (advance && in_item_r.action == pwft_pkg::ACT_COMPARE) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.action       <= in_if.action;
      in_item_r.capture_time <= in_if.capture_time;
    end
    if (advance && in_item_r.action == pwft_pkg::ACT_COMPARE) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= pwft_pkg::BASE_PERIOD_RST;
      data_word_r   <= pwft_pkg::DATA_WORD_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        pwft_pkg::CFG_BASE_PERIOD: base_period_r <= cfg_if.wdata[pwft_pkg::PERIOD_W-1:0];
        pwft_pkg::CFG_DATA_WORD:   data_word_r   <= cfg_if.wdata[pwft_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  pwft_seq #(
    .FRAME_BITS (FRAME_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (in_item_r),
    .base_period (base_period_r),
    .data_word   (data_word_r),
    .res         (res)
  );

  assign out_if.valid        = out_vld_r;
  assign out_if.next_compare = res_r.next_compare;
  assign out_if.pin_level    = res_r.pin_level;
  assign out_if.stop_timer   = res_r.stop_timer;

endmodule

/* hw/rtl/pwft_chk.sv */
// pwft_chk: port-level checks for pulse_width_frame_transmitter, with its bind
// depends on pwft_pkg, pulse_width_frame_transmitter

module pwft_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pwft_pkg::TIME_W-1:0]    out_next_compare,
  input logic                           out_pin_level,
  input logic                           out_stop_timer
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_compare) &&
      $stable(out_pin_level) && $stable(out_stop_timer))
    else $error("result changed while stalled");

  // idle answer is low pin and zero compare
  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_timer |-> !out_pin_level && out_next_compare == '0)
    else $error("stop result with nonzero fields");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result comes from an accepted compare request, through the input register
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2) &&
      $past(in_action, 2) == pwft_pkg::ACT_COMPARE)
    else $error("result without a compare request");

endmodule

bind pulse_width_frame_transmitter pwft_chk u_pwft_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_action        (in_if.action),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_next_compare (out_if.next_compare),
  .out_pin_level    (out_if.pin_level),
  .out_stop_timer   (out_if.stop_timer)
);
